@@ rtl/msfd_pkg.sv @@
// Shared types, codes and reset constants of the median smoothed fire detector.
// Used by the controller, the datapath and the top level. No dependencies.
`timescale 1ns / 1ps
package msfd_pkg;

  // Default geometry
  localparam int WINDOW_DEPTH_DEF = 30;
  localparam int MEDIAN_TAPS_DEF  = 5;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int STUCK_W  = 20;
  localparam int CFG_W    = 20;
  localparam int CIDX_W   = 3;
  localparam int COUNT_W  = 7;

  localparam logic [STUCK_W-1:0] STUCK_MAX = '1;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_RISE_THR   = 3'd0;
  localparam logic [CIDX_W-1:0] REG_FIXED_LVL  = 3'd1;
  localparam logic [CIDX_W-1:0] REG_FIXED_NEED = 3'd2;
  localparam logic [CIDX_W-1:0] REG_VALID_HI   = 3'd3;
  localparam logic [CIDX_W-1:0] REG_VALID_LO   = 3'd4;
  localparam logic [CIDX_W-1:0] REG_BAD_LIM    = 3'd5;
  localparam logic [CIDX_W-1:0] REG_STUCK_LIM  = 3'd6;

  // Register reset values
  localparam logic [15:0]        RISE_THR_RST   = 16'd8;
  localparam logic [15:0]        FIXED_LVL_RST  = 16'd58;
  localparam logic [COUNT_W-1:0] FIXED_NEED_RST = 7'd27;
  localparam logic [15:0]        VALID_HI_RST   = 16'd100;
  localparam logic [15:0]        VALID_LO_RST   = 16'hFFE9;  // -23
  localparam logic [COUNT_W-1:0] BAD_LIM_RST    = 7'd2;
  localparam logic [STUCK_W-1:0] STUCK_LIM_RST  = 20'd3000;

  typedef enum logic [2:0] {
    CAUSE_NONE  = 3'd0,
    CAUSE_BAD   = 3'd1,
    CAUSE_STUCK = 3'd2,
    CAUSE_RISE  = 3'd3,
    CAUSE_FIXED = 3'd4
  } cause_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH_RAW,
    ST_SCAN_RAW,
    ST_SORT,
    ST_PUSH_SM,
    ST_SCAN_SM,
    ST_DECIDE,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic push_raw;
    logic scan_raw;
    logic sort_step;
    logic push_sm;
    logic scan_sm;
    logic decide;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic alarm;
    logic med_ok;
    logic scan_done;
    logic sort_done;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/msfd_ram.sv @@
// Generic single write port RAM with one registered read port.
// Holds the raw and smoothed sample windows. No dependencies.
`timescale 1ns / 1ps
module msfd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 30
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/msfd_ctrl.sv @@
// Sequencer of the fire detector: walks push, scan, sort and decide steps.
// Depends on msfd_pkg for state, command and status types.
`timescale 1ns / 1ps
module msfd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  msfd_pkg::sts_t sts,
  output msfd_pkg::cmd_t cmd
);
  import msfd_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.alarm ? ST_DONE : ST_PUSH_RAW;
        end
      end
      ST_PUSH_RAW: begin
        cmd.push_raw = 1'b1;
        state_nxt    = ST_SCAN_RAW;
      end
      ST_SCAN_RAW: begin
        cmd.scan_raw = 1'b1;
        if (sts.scan_done) begin
          state_nxt = sts.med_ok ? ST_SORT : ST_DECIDE;
        end
      end
      ST_SORT: begin
        if (sts.sort_done) begin
          state_nxt = ST_PUSH_SM;
        end else begin
          cmd.sort_step = 1'b1;
        end
      end
      ST_PUSH_SM: begin
        cmd.push_sm = 1'b1;
        state_nxt   = ST_SCAN_SM;
      end
      ST_SCAN_SM: begin
        cmd.scan_sm = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/msfd_dp.sv @@
// Datapath of the fire detector: config registers, window RAMs, scan unit,
// median sorter, alarm latch and output register. Depends on msfd_pkg, msfd_ram.
`timescale 1ns / 1ps
module msfd_dp #(
  parameter int WINDOW_DEPTH = msfd_pkg::WINDOW_DEPTH_DEF,
  parameter int MEDIAN_TAPS  = msfd_pkg::MEDIAN_TAPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  msfd_pkg::cmd_t                      cmd,
  output msfd_pkg::sts_t                      sts,
  input  logic signed [msfd_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                cfg_we,
  input  logic [msfd_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [msfd_pkg::CFG_W-1:0]          cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_alarm,
  output logic [2:0]                          out_cause,
  output logic                                out_smoothed_valid,
  output logic signed [msfd_pkg::SAMPLE_W-1:0] out_smoothed_value
);
  import msfd_pkg::*;

  localparam int AW  = $clog2(WINDOW_DEPTH);
  localparam int FW  = $clog2(WINDOW_DEPTH + 1);
  localparam int BW  = $clog2(2 * WINDOW_DEPTH + 1);
  localparam int SW  = $clog2(MEDIAN_TAPS + 1);
  localparam int MID = (MEDIAN_TAPS - 1) / 2;
  localparam logic [AW-1:0] LAST_PTR = AW'(WINDOW_DEPTH - 1);
  localparam logic [FW-1:0] FULL     = FW'(WINDOW_DEPTH);
  localparam logic [SW-1:0] PASSES   = SW'(MEDIAN_TAPS);

  function automatic logic [AW-1:0] inc_ptr(input logic [AW-1:0] p);
    return (p == LAST_PTR) ? '0 : p + 1'b1;
  endfunction

  // ---------------- configuration registers
  logic [15:0]               rise_thr_r;
  logic signed [15:0]        fixed_lvl_r;
  logic [COUNT_W-1:0]        fixed_need_r;
  logic signed [15:0]        valid_hi_r;
  logic signed [15:0]        valid_lo_r;
  logic [COUNT_W-1:0]        bad_lim_r;
  logic [STUCK_W-1:0]        stuck_lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_thr_r   <= RISE_THR_RST;
      fixed_lvl_r  <= FIXED_LVL_RST;
      fixed_need_r <= FIXED_NEED_RST;
      valid_hi_r   <= VALID_HI_RST;
      valid_lo_r   <= VALID_LO_RST;
      bad_lim_r    <= BAD_LIM_RST;
      stuck_lim_r  <= STUCK_LIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RISE_THR:   rise_thr_r   <= cfg_data[15:0];
        REG_FIXED_LVL:  fixed_lvl_r  <= cfg_data[15:0];
        REG_FIXED_NEED: fixed_need_r <= cfg_data[COUNT_W-1:0];
        REG_VALID_HI:   valid_hi_r   <= cfg_data[15:0];
        REG_VALID_LO:   valid_lo_r   <= cfg_data[15:0];
        REG_BAD_LIM:    bad_lim_r    <= cfg_data[COUNT_W-1:0];
        REG_STUCK_LIM:  stuck_lim_r  <= cfg_data[STUCK_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- window pointers (circular buffers)
  logic signed [SAMPLE_W-1:0] sample_r;
  logic [AW-1:0] raw_head_r, raw_wr_r, sm_head_r, sm_wr_r;
  logic [FW-1:0] raw_fill_r, sm_fill_r;
  logic [AW-1:0] raw_head_nxt, sm_head_nxt;

  assign raw_head_nxt = (raw_fill_r == FULL) ? inc_ptr(raw_head_r) : raw_head_r;
  assign sm_head_nxt  = (sm_fill_r == FULL) ? inc_ptr(sm_head_r) : sm_head_r;

  logic signed [SAMPLE_W-1:0] med_r [MEDIAN_TAPS];
  logic signed [SAMPLE_W-1:0] med_val;
  assign med_val = med_r[MID];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_head_r <= '0;
      raw_wr_r   <= '0;
      raw_fill_r <= '0;
      sm_head_r  <= '0;
      sm_wr_r    <= '0;
      sm_fill_r  <= '0;
    end else begin
      if (cmd.push_raw) begin
        raw_wr_r   <= inc_ptr(raw_wr_r);
        raw_head_r <= raw_head_nxt;
        if (raw_fill_r != FULL) raw_fill_r <= raw_fill_r + 1'b1;
      end
      if (cmd.push_sm) begin
        sm_wr_r   <= inc_ptr(sm_wr_r);
        sm_head_r <= sm_head_nxt;
        if (sm_fill_r != FULL) sm_fill_r <= sm_fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) sample_r <= in_sample;
  end

  // ---------------- window memories
  logic [AW-1:0]          scan_ptr_r;
  logic [SAMPLE_W-1:0]    raw_q, sm_q;

  msfd_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW_DEPTH)) u_raw_ram (
    .clk   (clk),
    .we    (cmd.push_raw),
    .waddr (raw_wr_r),
    .wdata (sample_r),
    .raddr (scan_ptr_r),
    .rdata (raw_q)
  );

  msfd_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW_DEPTH)) u_sm_ram (
    .clk   (clk),
    .we    (cmd.push_sm),
    .waddr (sm_wr_r),
    .wdata (med_val),
    .raddr (scan_ptr_r),
    .rdata (sm_q)
  );

  // ---------------- scan unit: issue reads oldest to newest, process them in the next cycle
  logic [FW-1:0] scan_idx_r, proc_idx_r, fill_sel;
  logic          proc_v_r, issue;
  logic signed [SAMPLE_W-1:0] rd_data, prev_r, oldest_r, newest_r;
  logic [BW-1:0]      bad_cnt_r;
  logic [FW-1:0]      high_cnt_r;
  logic [STUCK_W-1:0] stuck_run_r;
  logic               scanning;

  assign scanning = cmd.scan_raw | cmd.scan_sm;
  assign fill_sel = cmd.scan_sm ? sm_fill_r : raw_fill_r;
  assign issue    = scanning && (scan_idx_r < fill_sel);
  assign rd_data  = cmd.scan_sm ? sm_q : raw_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proc_v_r    <= 1'b0;
      stuck_run_r <= '0;
    end else begin
      proc_v_r <= issue;
      // stuck-pair run, only while the raw window is full
      if (cmd.scan_raw && proc_v_r && raw_fill_r == FULL && proc_idx_r[0]) begin
        if (rd_data == prev_r) begin
          if (stuck_run_r != STUCK_MAX) stuck_run_r <= stuck_run_r + 1'b1;
        end else begin
          stuck_run_r <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    // scan start on each push
    if (cmd.push_raw || cmd.push_sm) begin
      scan_idx_r <= '0;
      scan_ptr_r <= cmd.push_raw ? raw_head_nxt : sm_head_nxt;
    end else if (issue) begin
      scan_idx_r <= scan_idx_r + 1'b1;
      scan_ptr_r <= inc_ptr(scan_ptr_r);
    end
    if (issue) proc_idx_r <= scan_idx_r;

    if (cmd.push_raw) bad_cnt_r <= '0;
    else if (cmd.scan_raw && proc_v_r)
      bad_cnt_r <= bad_cnt_r + BW'(rd_data > valid_hi_r) + BW'(rd_data < valid_lo_r);

    if (cmd.push_sm) high_cnt_r <= '0;
    else if (cmd.scan_sm && proc_v_r)
      high_cnt_r <= high_cnt_r + FW'(rd_data >= fixed_lvl_r);

    if (proc_v_r) prev_r <= rd_data;
    if (cmd.scan_sm && proc_v_r) begin
      newest_r <= rd_data;
      if (proc_idx_r == '0) oldest_r <= rd_data;
    end
  end

  // ---------------- median taps and odd-even transposition sort
  logic [SW-1:0] sort_cnt_r;
  logic signed [SAMPLE_W-1:0] med_nxt [MEDIAN_TAPS];

  always_comb begin
    for (int k = 0; k < MEDIAN_TAPS; k++) med_nxt[k] = med_r[k];
    if (cmd.scan_raw && proc_v_r) begin
      for (int k = 0; k < MEDIAN_TAPS - 1; k++) med_nxt[k] = med_r[k + 1];
      med_nxt[MEDIAN_TAPS - 1] = rd_data;
    end else if (cmd.sort_step) begin
      for (int k = 0; k < MEDIAN_TAPS - 1; k++) begin
        if (k[0] == sort_cnt_r[0] && med_r[k] > med_r[k + 1]) begin
          med_nxt[k]     = med_r[k + 1];
          med_nxt[k + 1] = med_r[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MEDIAN_TAPS; k++) med_r[k] <= med_nxt[k];
    if (cmd.push_raw) sort_cnt_r <= '0;
    else if (cmd.sort_step) sort_cnt_r <= sort_cnt_r + 1'b1;
  end

  // ---------------- alarm evaluation
  logic                alarm_r;
  cause_t              cause_r;
  logic                sv_r;
  logic signed [15:0]  smv_r;
  logic signed [16:0]  rise;
  logic                sm_full, bad_hit, stuck_hit, rise_hit, high_hit;

  assign sm_full   = (sm_fill_r == FULL);
  assign rise      = {newest_r[15], newest_r} - {oldest_r[15], oldest_r};
  assign bad_hit   = 32'(bad_cnt_r) > 32'(bad_lim_r);
  assign stuck_hit = stuck_run_r > stuck_lim_r;
  assign rise_hit  = sm_full && ($signed({rise[16], rise}) >= $signed({2'b00, rise_thr_r}));
  assign high_hit  = sm_full && (32'(high_cnt_r) >= 32'(fixed_need_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alarm_r <= 1'b0;
      cause_r <= CAUSE_NONE;
    end else if (cmd.decide && !alarm_r) begin
      if (bad_hit || stuck_hit || rise_hit || high_hit) alarm_r <= 1'b1;
      if (bad_hit)        cause_r <= CAUSE_BAD;
      else if (stuck_hit) cause_r <= CAUSE_STUCK;
      else if (rise_hit)  cause_r <= CAUSE_RISE;
      else if (high_hit)  cause_r <= CAUSE_FIXED;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sv_r  <= 1'b0;
      smv_r <= '0;
    end else if (cmd.push_sm) begin
      sv_r  <= 1'b1;
      smv_r <= med_val;
    end
  end

  // ---------------- output register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_alarm          <= alarm_r;
      out_cause          <= cause_r;
      out_smoothed_valid <= sv_r;
      out_smoothed_value <= smv_r;
    end
  end

  assign out_valid = out_valid_r;

  // ---------------- status
  always_comb begin
    sts           = '0;
    sts.alarm     = alarm_r;
    sts.med_ok    = 32'(raw_fill_r) >= 32'(MEDIAN_TAPS);
    sts.scan_done = (scan_idx_r == fill_sel) && !proc_v_r;
    sts.sort_done = (sort_cnt_r == PASSES);
    sts.out_free  = !out_valid_r || out_ready;
  end

  // ---------------- checks
  a_raw_fill: assert property (@(posedge clk) disable iff (!rst_n)
    raw_fill_r <= FULL) else $error("raw fill beyond window depth");
  a_sm_lag: assert property (@(posedge clk) disable iff (!rst_n)
    sm_fill_r <= raw_fill_r) else $error("smoothed fill ahead of raw fill");
  a_alarm_hold: assert property (@(posedge clk) disable iff (!rst_n)
    alarm_r |=> alarm_r) else $error("alarm latch dropped");
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    alarm_r == (cause_r != CAUSE_NONE)) else $error("cause disagrees with alarm");
  a_no_scan_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    $past(alarm_r) && alarm_r |-> !cmd.push_raw && !cmd.push_sm)
    else $error("window written after alarm");

endmodule

@@ rtl/median_smoothed_fire_detector_unit.sv @@
// Top level of the median smoothed fire detector: controller plus datapath.
// Depends on msfd_pkg, msfd_ctrl, msfd_dp (and msfd_ram below it).
//
//  Channel | Ports                                   | Transfer when
//  --------+-----------------------------------------+---------------------
//  in      | in_valid, in_ready, in_sample           | in_valid & in_ready
//  out     | out_valid, out_ready, out_alarm, ...    | out_valid & out_ready
//  cfg     | cfg_we, cfg_index, cfg_data             | cfg_we
//
// One sample at a time. With no alarm latched and both windows full, one RAM read port
// per window walks every stored entry, and the median sort takes one pass per tap.
// Once the alarm is latched a sample skips the window, scan and decide steps and
// goes straight to the output step. No clearing pass after reset.
// The output register frees the input side: the next sample is taken while a
// result still waits; the sequencer stalls only when it has a new result ready.
`timescale 1ns / 1ps
module median_smoothed_fire_detector_unit #(
  parameter int WINDOW_DEPTH = msfd_pkg::WINDOW_DEPTH_DEF,
  parameter int MEDIAN_TAPS  = msfd_pkg::MEDIAN_TAPS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [msfd_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_alarm,
  output logic [2:0]                           out_cause,
  output logic                                 out_smoothed_valid,
  output logic signed [msfd_pkg::SAMPLE_W-1:0] out_smoothed_value,
  input  logic                                 cfg_we,
  input  logic [msfd_pkg::CIDX_W-1:0]          cfg_index,
  input  logic [msfd_pkg::CFG_W-1:0]           cfg_data
);
  import msfd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  msfd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  msfd_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .MEDIAN_TAPS  (MEDIAN_TAPS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_sample          (in_sample),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_alarm          (out_alarm),
    .out_cause          (out_cause),
    .out_smoothed_valid (out_smoothed_valid),
    .out_smoothed_value (out_smoothed_value)
  );

endmodule
